FILE: hw/rtl/rrqs_pkg.sv
package rrqs_pkg;

  localparam int TASK_ID_W = 8;
  localparam int TIME_W    = 16;
  localparam int STATUS_W  = 3;

  // Result buffer: four entries, so a step's two results fit behind two waiting ones
  localparam int OUT_DEPTH = 4;
  localparam int OUT_IDX_W = 2;
  localparam int OUT_CNT_W = 3;

  localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd4;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_STEP   = 1'b1;
  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_REQUEUED = 3'd0,
    ST_FINISHED = 3'd1,
    ST_IDLE     = 3'd2,
    ST_ADDED    = 3'd3,
    ST_DROPPED  = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SERVE
  } state_t;

  typedef struct packed {
    logic rd;
    logic push;
    logic pop;
  } q_cmd_t;

  typedef struct packed {
    logic                 last;
    status_t              status;
    logic                 queue_side;
    logic [TASK_ID_W-1:0] served_id;
    logic [TIME_W-1:0]    ran_time;
    logic [TIME_W-1:0]    time_left;
  } res_t;

endpackage

FILE: hw/rtl/rrqs_queue.sv
module rrqs_queue #(
  parameter int  DEPTH = 16,
  parameter int  ID_W  = 8,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rrqs_pkg::q_cmd_t            cmd,
  input  logic [ID_W-1:0]             wr_id,
  input  logic [rrqs_pkg::TIME_W-1:0] wr_rem,
  output logic [ID_W-1:0]             rd_id,
  output logic [rrqs_pkg::TIME_W-1:0] rd_rem,
  output logic [CNT_W-1:0]            count
);

  localparam int ENTRY_W = ID_W + rrqs_pkg::TIME_W;
  localparam int SUM_W   = CNT_W + 1;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   head_inc;
  logic [SUM_W-1:0]   tail_sum;
  logic [SUM_W-1:0]   tail_wrap;
  logic [IDX_W-1:0]   tail;

  // Tail slot: head plus count, folded once into the ring
  always_comb begin
    tail_sum  = SUM_W'(head) + SUM_W'(count);
    tail_wrap = tail_sum - SUM_W'(DEPTH);
    tail      = (tail_sum >= SUM_W'(DEPTH)) ? tail_wrap[IDX_W-1:0] : tail_sum[IDX_W-1:0];
    head_inc  = (head == IDX_W'(DEPTH - 1)) ? '0 : head + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= {wr_id, wr_rem};
    end
    if (cmd.rd) begin
      rd_data <= mem[head];
    end
  end

  assign rd_id  = rd_data[ENTRY_W-1:rrqs_pkg::TIME_W];
  assign rd_rem = rd_data[rrqs_pkg::TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (cmd.pop) begin
        head <= head_inc;
      end
      unique case ({cmd.push, cmd.pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (count != '0))
    else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && !cmd.pop) |-> (count < CNT_W'(DEPTH)))
    else $error("push into full queue");

endmodule

FILE: hw/rtl/round_robin_quantum_scheduler.sv
// Timing: an add result is registered into the result buffer as the item is accepted; step
//   results pass through the queue read registers holding the head entries, then the buffer.
// Flow: a step goes through a head read, then serve and write back, and holds off input until
//   done; input is also held off while the four-entry result buffer has under two free slots.
// Reset: both queues empty (head and count zero), quantum 4, result buffer empty.
//   Queue memories are not cleared; a head read of an empty queue is never used.
module round_robin_quantum_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Quantum register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // task_id[7:0], burst_time[23:8]
  input  logic [1:0]  s_axis_tuser,   // action[0], side[1]
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // served_id[7:0], ran_time[23:8], time_left[39:24]
  output logic [3:0]  m_axis_tuser,   // queue_side[0], status[3:1]
  output logic        m_axis_tlast
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TW    = rrqs_pkg::TIME_W;

  rrqs_pkg::state_t state, state_next;

  logic [TW-1:0] quantum;
  logic [TW-1:0] qu_eff;

  logic                              s_acc, m_acc, is_step, add_side;
  logic [rrqs_pkg::TASK_ID_W-1:0]    in_id;
  logic [TW-1:0]                     in_burst;
  logic [ID_WIDTH-1:0]               in_id_kept;

  rrqs_pkg::q_cmd_t    l_cmd, r_cmd;
  logic [ID_WIDTH-1:0] l_wr_id, r_wr_id, l_rd_id, r_rd_id;
  logic [TW-1:0]       l_wr_rem, r_wr_rem, l_rd_rem, r_rd_rem;
  logic [CNT_W-1:0]    l_count, r_count;
  logic                l_busy, r_busy, l_full, r_full, add_full;

  logic [TW-1:0] l_ran, r_ran, l_left, r_left;
  logic          l_requeue, r_requeue;

  rrqs_pkg::res_t add_res, l_res, r_res, idle_res;
  rrqs_pkg::res_t wr0_data, wr1_data, out_res;
  logic           wr0_en, wr1_en;

  rrqs_pkg::res_t                  obuf [rrqs_pkg::OUT_DEPTH];
  logic [rrqs_pkg::OUT_IDX_W-1:0]  ord, owr;
  logic [rrqs_pkg::OUT_CNT_W-1:0]  ocount;

  // Unpack the input item
  assign is_step    = (s_axis_tuser[0] == rrqs_pkg::ACT_STEP);
  assign add_side   = s_axis_tuser[1];
  assign in_id      = s_axis_tdata[7:0];
  assign in_burst   = s_axis_tdata[23:8];
  assign in_id_kept = ID_WIDTH'(in_id);

  // Quantum register; zero is stored but acts as one
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= rrqs_pkg::QUANTUM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      quantum <= cfg_data;
    end
  end
  assign qu_eff = (quantum == '0) ? TW'(1) : quantum;

  // Queue occupancy. Counts stay put from step acceptance into the serve cycle.
  assign l_busy   = (l_count != '0);
  assign r_busy   = (r_count != '0);
  assign l_full   = (l_count == CNT_W'(QUEUE_DEPTH));
  assign r_full   = (r_count == CNT_W'(QUEUE_DEPTH));
  assign add_full = (add_side == rrqs_pkg::SIDE_RIGHT) ? r_full : l_full;

  // Serve arithmetic on the head entries read last cycle
  always_comb begin
    l_ran     = (l_rd_rem < qu_eff) ? l_rd_rem : qu_eff;
    r_ran     = (r_rd_rem < qu_eff) ? r_rd_rem : qu_eff;
    l_left    = l_rd_rem - l_ran;
    r_left    = r_rd_rem - r_ran;
    l_requeue = (l_left != '0);
    r_requeue = (r_left != '0);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rrqs_pkg::S_IDLE:  if (s_acc && is_step) state_next = rrqs_pkg::S_SERVE;
      rrqs_pkg::S_SERVE: state_next = rrqs_pkg::S_IDLE;
      default:           state_next = rrqs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrqs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control outputs: accept only in the idle state and when the buffer can absorb a full step
  always_comb begin
    s_axis_tready = (state == rrqs_pkg::S_IDLE) &&
                    (ocount <= rrqs_pkg::OUT_CNT_W'(rrqs_pkg::OUT_DEPTH - 2));
    s_acc = s_axis_tvalid && s_axis_tready;

    l_cmd = '0;
    r_cmd = '0;
    l_wr_id  = in_id_kept;
    r_wr_id  = in_id_kept;
    l_wr_rem = in_burst;
    r_wr_rem = in_burst;

    unique case (state)
      rrqs_pkg::S_IDLE: begin
        // Step: fetch both heads. Add: append at the tail if there is room.
        l_cmd.rd   = s_acc && is_step;
        r_cmd.rd   = s_acc && is_step;
        l_cmd.push = s_acc && !is_step && (add_side == rrqs_pkg::SIDE_LEFT) && !l_full;
        r_cmd.push = s_acc && !is_step && (add_side == rrqs_pkg::SIDE_RIGHT) && !r_full;
      end
      rrqs_pkg::S_SERVE: begin
        // Drop the head, and put it back at the tail while time remains
        l_cmd.pop  = l_busy;
        r_cmd.pop  = r_busy;
        l_cmd.push = l_busy && l_requeue;
        r_cmd.push = r_busy && r_requeue;
        l_wr_id    = l_rd_id;
        r_wr_id    = r_rd_id;
        l_wr_rem   = l_left;
        r_wr_rem   = r_left;
      end
      default: begin
        l_cmd = '0;
        r_cmd = '0;
      end
    endcase
  end

  rrqs_queue #(
    .DEPTH (QUEUE_DEPTH),
    .ID_W  (ID_WIDTH)
  ) u_left (
    .clk    (clk),
    .rst    (rst),
    .cmd    (l_cmd),
    .wr_id  (l_wr_id),
    .wr_rem (l_wr_rem),
    .rd_id  (l_rd_id),
    .rd_rem (l_rd_rem),
    .count  (l_count)
  );

  rrqs_queue #(
    .DEPTH (QUEUE_DEPTH),
    .ID_W  (ID_WIDTH)
  ) u_right (
    .clk    (clk),
    .rst    (rst),
    .cmd    (r_cmd),
    .wr_id  (r_wr_id),
    .wr_rem (r_wr_rem),
    .rd_id  (r_rd_id),
    .rd_rem (r_rd_rem),
    .count  (r_count)
  );

  // Build result items
  always_comb begin
    add_res.last       = 1'b1;
    add_res.status     = add_full ? rrqs_pkg::ST_DROPPED : rrqs_pkg::ST_ADDED;
    add_res.queue_side = add_side;
    add_res.served_id  = rrqs_pkg::TASK_ID_W'(in_id_kept);
    add_res.ran_time   = '0;
    add_res.time_left  = in_burst;

    l_res.last       = 1'b1;
    l_res.status     = l_requeue ? rrqs_pkg::ST_REQUEUED : rrqs_pkg::ST_FINISHED;
    l_res.queue_side = rrqs_pkg::SIDE_LEFT;
    l_res.served_id  = rrqs_pkg::TASK_ID_W'(l_rd_id);
    l_res.ran_time   = l_ran;
    l_res.time_left  = l_left;

    r_res.last       = 1'b1;
    r_res.status     = r_requeue ? rrqs_pkg::ST_REQUEUED : rrqs_pkg::ST_FINISHED;
    r_res.queue_side = rrqs_pkg::SIDE_RIGHT;
    r_res.served_id  = rrqs_pkg::TASK_ID_W'(r_rd_id);
    r_res.ran_time   = r_ran;
    r_res.time_left  = r_left;

    idle_res            = '0;
    idle_res.last       = 1'b1;
    idle_res.status     = rrqs_pkg::ST_IDLE;
    idle_res.queue_side = rrqs_pkg::SIDE_LEFT;

    wr0_en   = 1'b0;
    wr1_en   = 1'b0;
    wr0_data = add_res;
    wr1_data = r_res;

    priority if (state == rrqs_pkg::S_IDLE) begin
      wr0_en = s_acc && !is_step;
    end else if (l_busy && r_busy) begin
      // Left first, right carries the last mark
      wr0_en        = 1'b1;
      wr1_en        = 1'b1;
      wr0_data      = l_res;
      wr0_data.last = 1'b0;
    end else if (l_busy) begin
      wr0_en   = 1'b1;
      wr0_data = l_res;
    end else if (r_busy) begin
      wr0_en   = 1'b1;
      wr0_data = r_res;
    end else begin
      wr0_en   = 1'b1;
      wr0_data = idle_res;
    end
  end

  // Result buffer: up to two writes per cycle, one read
  always_ff @(posedge clk) begin
    if (wr0_en) begin
      obuf[owr] <= wr0_data;
    end
    if (wr1_en) begin
      obuf[owr + 1'b1] <= wr1_data;
    end
  end

  assign m_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ord    <= '0;
      owr    <= '0;
      ocount <= '0;
    end else begin
      owr    <= owr + rrqs_pkg::OUT_IDX_W'(wr0_en) + rrqs_pkg::OUT_IDX_W'(wr1_en);
      ord    <= ord + rrqs_pkg::OUT_IDX_W'(m_acc);
      ocount <= ocount + rrqs_pkg::OUT_CNT_W'(wr0_en) + rrqs_pkg::OUT_CNT_W'(wr1_en)
                - rrqs_pkg::OUT_CNT_W'(m_acc);
    end
  end

  assign out_res       = obuf[ord];
  assign m_axis_tvalid = (ocount != '0);
  assign m_axis_tdata  = {out_res.time_left, out_res.ran_time, out_res.served_id};
  assign m_axis_tuser  = {out_res.status, out_res.queue_side};
  assign m_axis_tlast  = out_res.last;

  a_obuf_bound: assert property (@(posedge clk) disable iff (rst)
    ocount <= rrqs_pkg::OUT_CNT_W'(rrqs_pkg::OUT_DEPTH))
    else $error("result buffer overflow");

  a_serve_room: assert property (@(posedge clk) disable iff (rst)
    (state == rrqs_pkg::S_SERVE) |->
      (ocount <= rrqs_pkg::OUT_CNT_W'(rrqs_pkg::OUT_DEPTH - 2)))
    else $error("no room for step results");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> (m_axis_tvalid || (state == rrqs_pkg::S_SERVE)))
    else $error("accepted item produced no progress");

endmodule
